// ===== hw/rtl/vac_pkg.sv =====
package vac_pkg;

  // fixed alphabet and store geometry
  localparam int KEY_MAX    = 64;
  localparam int ALPHA_SIZE = 55;
  localparam int IDX_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int PTR_W      = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KEY_LEN_W  = 7;
  localparam int LEN_W      = (KEY_LEN_W > $clog2(KEY_MAX + 1)) ? KEY_LEN_W
                                                                 : $clog2(KEY_MAX + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = KEY_LEN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION  = 2'd0,
    CFG_KEY_MODE   = 2'd1,
    CFG_KEY_LENGTH = 2'd2
  } cfg_reg_t;

  localparam logic FUNC_KEY = 1'b0;
  localparam logic FUNC_MSG = 1'b1;
  localparam logic DIR_ENC  = 1'b0;
  localparam logic MODE_AUTOKEY = 1'b1;

  // request from the control stage to the memories and the compute stage
  typedef struct packed {
    logic             key_we;
    logic [PTR_W-1:0] key_waddr;
    logic [IDX_W-1:0] key_wdata;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             use_hist;
  } vac_req_t;

  // character code to {found, alphabet index}
  function automatic logic [IDX_W:0] alpha_index(input logic [CHAR_W-1:0] code);
    logic [IDX_W:0] r;
    r = '0;
    if (code >= 8'h61 && code <= 8'h7a) begin
      r = {1'b1, IDX_W'(code - 8'h61)};
    end else if (code >= 8'h41 && code <= 8'h5a) begin
      r = {1'b1, IDX_W'(code - 8'h41 + 8'd27)};
    end else if (code == 8'h20) begin
      r = {1'b1, IDX_W'(26)};
    end else if (code == 8'h2c) begin
      r = {1'b1, IDX_W'(53)};
    end else if (code == 8'h2e) begin
      r = {1'b1, IDX_W'(54)};
    end
    return r;
  endfunction

  // alphabet index to character code
  function automatic logic [CHAR_W-1:0] alpha_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (idx < IDX_W'(26)) begin
      c = CHAR_W'(idx) + 8'h61;
    end else if (idx == IDX_W'(26)) begin
      c = 8'h20;
    end else if (idx < IDX_W'(53)) begin
      c = CHAR_W'(idx) + 8'd38;
    end else if (idx == IDX_W'(53)) begin
      c = 8'h2c;
    end else if (idx == IDX_W'(54)) begin
      c = 8'h2e;
    end
    return c;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(KEY_MAX - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/vac_if.sv =====
interface vac_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [vac_pkg::CHAR_W-1:0] char_in;
  logic                       first;

  modport source (output valid, func, char_in, first, input ready);
  modport sink   (input valid, func, char_in, first, output ready);
endinterface

interface vac_out_if;
  logic                       valid;
  logic                       ready;
  logic [vac_pkg::CHAR_W-1:0] char_out;
  logic                       status;

  modport source (output valid, char_out, status, input ready);
  modport sink   (input valid, char_out, status, output ready);
endinterface

// ===== hw/rtl/vac_ram.sv =====
module vac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/vac_ctrl.sv =====
module vac_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vac_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           accept,
  input  logic                           func,
  input  logic                           first,
  input  logic                           found,
  input  logic [vac_pkg::IDX_W-1:0]      idx,
  output vac_pkg::vac_req_t              req,
  output logic [vac_pkg::PTR_W-1:0]      key_ptr,
  output logic                           direction
);

  logic                           dir_r;
  logic                           mode_r;
  logic [vac_pkg::KEY_LEN_W-1:0]  klen_r;
  logic [vac_pkg::PTR_W-1:0]      klp_r, klp_nxt;
  logic [vac_pkg::PTR_W-1:0]      slot_r, slot_nxt;
  logic                           pfp_r, pfp_nxt;

  logic [vac_pkg::LEN_W-1:0]      klen_ext, len;
  logic [vac_pkg::PTR_W-1:0]      kp, slot0, slot;
  logic [vac_pkg::LEN_W-1:0]      slot_inc;
  logic                           pfp0, pfp1, wrap0, wrap1;

  // effective key length, clamped to 1..KEY_MAX
  always_comb begin
    klen_ext = vac_pkg::LEN_W'(klen_r);
    if (klen_ext == '0) begin
      len = vac_pkg::LEN_W'(1);
    end else if (klen_ext > vac_pkg::LEN_W'(vac_pkg::KEY_MAX)) begin
      len = vac_pkg::LEN_W'(vac_pkg::KEY_MAX);
    end else begin
      len = klen_ext;
    end
  end

  always_comb begin
    kp      = first ? '0 : klp_r;
    klp_nxt = vac_pkg::ptr_inc(kp);

    slot0    = first ? '0 : slot_r;
    pfp0     = first ? 1'b0 : pfp_r;
    wrap0    = vac_pkg::LEN_W'(slot0) >= len;
    slot     = wrap0 ? '0 : slot0;
    pfp1     = pfp0 | wrap0;
    slot_inc = vac_pkg::LEN_W'(slot) + 1'b1;
    wrap1    = slot_inc >= len;
    slot_nxt = wrap1 ? '0 : slot_inc[vac_pkg::PTR_W-1:0];
    pfp_nxt  = pfp1 | wrap1;
  end

  always_comb begin
    req.key_we    = accept && (func == vac_pkg::FUNC_KEY);
    req.key_waddr = kp;
    req.key_wdata = found ? idx : '0;
    req.rd_en     = accept && (func == vac_pkg::FUNC_MSG);
    req.rd_addr   = slot;
    req.use_hist  = (mode_r == vac_pkg::MODE_AUTOKEY) && pfp1;
  end

  assign key_ptr   = klp_r;
  assign direction = dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= 1'b0;
      mode_r <= 1'b0;
      klen_r <= vac_pkg::KEY_LEN_W'(1);
      klp_r  <= '0;
      slot_r <= '0;
      pfp_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vac_pkg::CFG_DIRECTION:  dir_r  <= cfg_data[0];
          vac_pkg::CFG_KEY_MODE:   mode_r <= cfg_data[0];
          vac_pkg::CFG_KEY_LENGTH: klen_r <= cfg_data;
          default: ;
        endcase
      end
      if (req.key_we) begin
        klp_r <= klp_nxt;
      end
      if (req.rd_en) begin
        slot_r <= slot_nxt;
        pfp_r  <= pfp_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/vac_alu.sv =====
module vac_alu (
  input  logic                        msg,
  input  logic                        direction,
  input  logic [vac_pkg::CHAR_W-1:0]  char_in,
  input  logic                        found,
  input  logic [vac_pkg::IDX_W-1:0]   idx,
  input  logic [vac_pkg::IDX_W-1:0]   key_raw,
  output logic [vac_pkg::CHAR_W-1:0]  char_out,
  output logic                        status,
  output logic [vac_pkg::IDX_W-1:0]   plain
);

  logic [vac_pkg::IDX_W-1:0] key, res;
  logic [vac_pkg::IDX_W:0]   sum, diff;

  always_comb begin
    key = (key_raw >= vac_pkg::IDX_W'(vac_pkg::ALPHA_SIZE))
          ? key_raw - vac_pkg::IDX_W'(vac_pkg::ALPHA_SIZE) : key_raw;
    if (direction == vac_pkg::DIR_ENC) begin
      sum = {1'b0, idx} + {1'b0, key};
    end else begin
      sum = {1'b0, idx} + (vac_pkg::IDX_W+1)'(vac_pkg::ALPHA_SIZE) - {1'b0, key};
    end
    diff = (sum >= (vac_pkg::IDX_W+1)'(vac_pkg::ALPHA_SIZE))
           ? sum - (vac_pkg::IDX_W+1)'(vac_pkg::ALPHA_SIZE) : sum;
    res  = diff[vac_pkg::IDX_W-1:0];

    status = !found;
    if (!found) begin
      plain = '0;
    end else if (direction == vac_pkg::DIR_ENC) begin
      plain = idx;
    end else begin
      plain = res;
    end
    char_out = (msg && found) ? vac_pkg::alpha_char(res) : char_in;
  end

endmodule

// ===== hw/rtl/vigenere_autokey_stream_cipher.sv =====
// channel   dir  transaction payload            notes
// in_if     in   func, char_in[7:0], first      key load (func 0) or message char
// out_if    out  char_out[7:0], status          one per input, in order
// cfg_*     in   cfg_index[1:0], cfg_data[6:0]  direction, key_mode, key_length
//
// one character per cycle sustained unless out_if stalls; an accepted input
// goes through the compute stage to the output register (stores read in the
// accept cycle, compute and write back as the compute stage moves on). reset
// is synchronous active low and clears control only, not the key and history
// stores. a stall on out_if holds the compute stage and output register; input
// is still taken while the output register waits, if the compute stage is empty.
module vigenere_autokey_stream_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  vac_in_if.sink                         in_if,
  vac_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [vac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vac_pkg::CFG_DATA_W-1:0] cfg_data
);

  // input side
  logic                        in_accept;
  logic [vac_pkg::IDX_W:0]     lookup;
  logic                        in_found;
  logic [vac_pkg::IDX_W-1:0]   in_idx;
  vac_pkg::vac_req_t           req;
  logic [vac_pkg::PTR_W-1:0]   key_ptr;
  logic                        direction;

  // memory read data, valid in the cycle after the accept
  logic [vac_pkg::IDX_W-1:0]   key_rd_r;
  logic [vac_pkg::IDX_W-1:0]   hist_rd_r;

  // compute stage
  logic                        s1_valid_r;
  logic                        s1_msg_r;
  logic [vac_pkg::CHAR_W-1:0]  s1_char_r;
  logic                        s1_found_r;
  logic [vac_pkg::IDX_W-1:0]   s1_idx_r;
  logic [vac_pkg::PTR_W-1:0]   s1_slot_r;
  logic                        s1_hist_r;
  logic                        s1_fwd_r;
  logic [vac_pkg::IDX_W-1:0]   s1_fwd_data_r;
  logic                        s1_advance;
  logic                        fwd_hit;
  logic [vac_pkg::IDX_W-1:0]   key_raw;
  logic [vac_pkg::CHAR_W-1:0]  res_char;
  logic                        res_status;
  logic [vac_pkg::IDX_W-1:0]   res_plain;
  logic                        hist_we;

  // output register
  logic                        out_valid_r;
  logic [vac_pkg::CHAR_W-1:0]  out_char_r;
  logic                        out_status_r;

  assign lookup   = vac_pkg::alpha_index(in_if.char_in);
  assign in_found = lookup[vac_pkg::IDX_W];
  assign in_idx   = lookup[vac_pkg::IDX_W-1:0];

  // compute stage moves when the output register is free or being drained
  assign s1_advance  = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_advance;
  assign in_accept   = in_if.valid && in_if.ready;

  vac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_accept),
    .func      (in_if.func),
    .first     (in_if.first),
    .found     (in_found),
    .idx       (in_idx),
    .req       (req),
    .key_ptr   (key_ptr),
    .direction (direction)
  );

  // key store: written straight from the accepted key load
  vac_ram #(
    .WIDTH (vac_pkg::IDX_W),
    .DEPTH (vac_pkg::KEY_MAX)
  ) u_key_ram (
    .clk     (clk),
    .we      (req.key_we),
    .waddr   (req.key_waddr),
    .wdata   (req.key_wdata),
    .re      (req.rd_en),
    .raddr   (req.rd_addr),
    .rdata_r (key_rd_r)
  );

  // plaintext history: read at accept, written back from the compute stage
  assign hist_we = s1_advance && s1_msg_r;

  vac_ram #(
    .WIDTH (vac_pkg::IDX_W),
    .DEPTH (vac_pkg::KEY_MAX)
  ) u_hist_ram (
    .clk     (clk),
    .we      (hist_we),
    .waddr   (s1_slot_r),
    .wdata   (res_plain),
    .re      (req.rd_en),
    .raddr   (req.rd_addr),
    .rdata_r (hist_rd_r)
  );

  // same slot read while the previous message writes it back (key length 1,
  // or a message restart on slot 0): the ram returns old data, so forward
  assign fwd_hit = hist_we && req.rd_en && (s1_slot_r == req.rd_addr);

  always_comb begin
    if (!s1_hist_r) begin
      key_raw = key_rd_r;
    end else if (s1_fwd_r) begin
      key_raw = s1_fwd_data_r;
    end else begin
      key_raw = hist_rd_r;
    end
  end

  vac_alu u_alu (
    .msg       (s1_msg_r),
    .direction (direction),
    .char_in   (s1_char_r),
    .found     (s1_found_r),
    .idx       (s1_idx_r),
    .key_raw   (key_raw),
    .char_out  (res_char),
    .status    (res_status),
    .plain     (res_plain)
  );

  // control of the compute stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_msg_r      <= (in_if.func == vac_pkg::FUNC_MSG);
      s1_char_r     <= in_if.char_in;
      s1_found_r    <= in_found;
      s1_idx_r      <= in_idx;
      s1_slot_r     <= req.rd_addr;
      s1_hist_r     <= req.use_hist;
      s1_fwd_r      <= fwd_hit;
      s1_fwd_data_r <= res_plain;
    end
    if (s1_advance) begin
      out_char_r   <= res_char;
      out_status_r <= res_status;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.char_out = out_char_r;
  assign out_if.status   = out_status_r;

  // a forward flag in a live compute stage only ever belongs to a message
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r && s1_valid_r |-> s1_msg_r)
    else $error("forward flag on a non-message transaction");

  // key load pointer steps by one per key load that does not restart
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_if.func == vac_pkg::FUNC_KEY) && !in_if.first
    |=> key_ptr == vac_pkg::ptr_inc($past(key_ptr)))
    else $error("key load pointer did not advance");

  // every compute stage move lands in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance |=> out_valid_r)
    else $error("result lost between compute stage and output register");

  // history is written back exactly for message transactions leaving the stage
  assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> s1_valid_r && s1_msg_r)
    else $error("history write without a message in flight");

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // alphabet in index order, used by the cipher predictor
  localparam string SYMBOLS = "abcdefghijklmnopqrstuvwxyz ABCDEFGHIJKLMNOPQRSTUVWXYZ,.";
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 8;

  // one input transaction and one output transaction
  typedef struct packed {
    bit       func;
    bit [7:0] code;
    bit       first;
  } cipher_item_t;

  typedef struct packed {
    bit [7:0] code;
    bit       status;
  } cipher_out_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  vac_pkg::cfg_reg_t cfg_index;
  logic [vac_pkg::CFG_DATA_W-1:0] cfg_data;

  vac_in_if  in_ch ();
  vac_out_if out_ch ();

  vigenere_autokey_stream_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register shadow, shared by both cipher copies (written only when idle)
  bit       cfg_dir  = vac_pkg::DIR_ENC;
  bit       cfg_mode = 1'b0;
  bit [6:0] cfg_len  = 7'd1;

  // two copies of the cipher state: 0 follows stimulus generation,
  // 1 follows accepted transactions and produces the expected output
  bit [5:0] key_mem  [2][vac_pkg::KEY_MAX];
  bit [5:0] hist_mem [2][vac_pkg::KEY_MAX];
  bit       key_ok   [2][vac_pkg::KEY_MAX];
  bit       hist_ok  [2][vac_pkg::KEY_MAX];
  int       load_ptr [2];
  int       slot_pos [2];
  bit       wrapped  [2];

  cipher_item_t pending_chars[$];
  cipher_out_t  expected_chars[$];

  int  fed;
  int  results_seen;
  int  err_count;
  int  in_wait;
  int  out_wait;
  int  out_gap;
  bit  in_burst;
  bit  out_burst;
  bit  hold_go;
  logic out_hold;

  cipher_item_t taken;
  cipher_out_t  predicted;
  cipher_out_t  wanted;

  // clock, 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int sym_index(input bit [7:0] code);
    int i;
    for (i = 0; i < vac_pkg::ALPHA_SIZE; i++) begin
      if (SYMBOLS[i] == code) return i;
    end
    return -1;
  endfunction

  // key length as the block uses it: 0 acts as 1, anything above the store as full
  function automatic int eff_len();
    int l;
    l = int'(cfg_len);
    if (l == 0) l = 1;
    if (l > vac_pkg::KEY_MAX) l = vac_pkg::KEY_MAX;
    return l;
  endfunction

  function automatic bit [7:0] rand_symbol();
    return SYMBOLS[$urandom_range(0, vac_pkg::ALPHA_SIZE - 1)];
  endfunction

  // mostly alphabet characters, sometimes any byte
  function automatic bit [7:0] rand_char();
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    return rand_symbol();
  endfunction

  // would a message character read a store entry that was never written
  function automatic bit read_ok(input int m, input bit first);
    int s;
    bit w;
    s = first ? 0 : slot_pos[m];
    w = first ? 1'b0 : wrapped[m];
    if (s >= eff_len()) begin
      s = 0;
      w = 1'b1;
    end
    if (cfg_mode == vac_pkg::MODE_AUTOKEY && w) return hist_ok[m][s];
    return key_ok[m][s];
  endfunction

  // one step of the cipher on copy m
  function automatic void cipher_step(input int m, input cipher_item_t it,
                                      output cipher_out_t res);
    int idx;
    int len;
    int s;
    int k;
    int pt;
    int r;
    idx = sym_index(it.code);
    if (it.func == vac_pkg::FUNC_KEY) begin
      // key load: out-of-alphabet characters are stored as index 0
      if (it.first) load_ptr[m] = 0;
      key_mem[m][load_ptr[m]] = (idx < 0) ? 6'd0 : 6'(idx);
      key_ok[m][load_ptr[m]] = 1'b1;
      load_ptr[m] = (load_ptr[m] + 1) % vac_pkg::KEY_MAX;
      res.code = it.code;
      res.status = (idx < 0);
    end else begin
      len = eff_len();
      if (it.first) begin
        slot_pos[m] = 0;
        wrapped[m] = 1'b0;
      end
      s = slot_pos[m];
      // slot left beyond a lowered key length restarts at zero
      if (s >= len) begin
        s = 0;
        wrapped[m] = 1'b1;
      end
      if (cfg_mode == vac_pkg::MODE_AUTOKEY && wrapped[m]) k = int'(hist_mem[m][s]);
      else k = int'(key_mem[m][s]);
      k = k % vac_pkg::ALPHA_SIZE;
      if (idx < 0) begin
        res.code = it.code;
        res.status = 1'b1;
        pt = 0;
      end else begin
        if (cfg_dir == vac_pkg::DIR_ENC) begin
          r = (idx + k) % vac_pkg::ALPHA_SIZE;
          pt = idx;
        end else begin
          r = (idx + vac_pkg::ALPHA_SIZE - k) % vac_pkg::ALPHA_SIZE;
          pt = r;
        end
        res.code = SYMBOLS[r];
        res.status = 1'b0;
      end
      hist_mem[m][s] = 6'(pt);
      hist_ok[m][s] = 1'b1;
      s++;
      if (s >= len) begin
        s = 0;
        wrapped[m] = 1'b1;
      end
      slot_pos[m] = s;
    end
  endfunction

  // queue one item; a message char that would hit an unwritten entry
  // restarts the message, or becomes a key load if even that is not safe
  task automatic offer(input bit func, input bit [7:0] code, input bit first);
    cipher_item_t it;
    cipher_out_t  unused;
    if (func == vac_pkg::FUNC_MSG && !read_ok(0, first)) first = 1'b1;
    if (func == vac_pkg::FUNC_MSG && !read_ok(0, first)) func = vac_pkg::FUNC_KEY;
    it.func = func;
    it.code = code;
    it.first = first;
    cipher_step(0, it, unused);
    pending_chars.push_back(it);
    fed++;
  endtask

  task automatic write_reg(input vac_pkg::cfg_reg_t r, input bit [6:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      vac_pkg::CFG_DIRECTION:  cfg_dir = v[0];
      vac_pkg::CFG_KEY_MODE:   cfg_mode = v[0];
      vac_pkg::CFG_KEY_LENGTH: cfg_len = v;
      default: ;
    endcase
  endtask

  // every queued item has produced its output transaction
  task automatic wait_idle();
    while (results_seen < fed) @(posedge clk);
  endtask

  // driver: presents queued items, random gap after each one outside a burst
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_wait <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        // accepted transaction: predict its output now
        taken.func = in_ch.func;
        taken.code = in_ch.char_in;
        taken.first = in_ch.first;
        cipher_step(1, taken, predicted);
        expected_chars.push_back(predicted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_wait > 0 || pending_chars.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (in_wait > 0) in_wait <= in_wait - 1;
        end else begin
          taken = pending_chars.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= taken.func;
          in_ch.char_in <= taken.code;
          in_ch.first <= taken.first;
          in_wait <= in_burst ? 0 : int'($urandom_range(0, 3));
        end
      end
    end
  end

  // monitor: checks each output transaction, random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_chars.size() == 0) begin
          flag_error($sformatf("output %02h with nothing expected", out_ch.char_out));
        end else begin
          wanted = expected_chars.pop_front();
          if (out_ch.char_out !== wanted.code)
            flag_error($sformatf("char_out %02h, expected %02h",
                                 out_ch.char_out, wanted.code));
          if (out_ch.status !== wanted.status)
            flag_error($sformatf("status %b, expected %b (char %02h)",
                                 out_ch.status, wanted.status, wanted.code));
        end
        // a zero gap keeps ready high for back-to-back transactions unless the hold-off is on
        out_gap = out_burst ? 0 : int'($urandom_range(0, 3));
        out_wait <= out_gap;
        out_ch.ready <= (out_gap == 0) && !out_hold;
      end else if (out_hold) begin
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_ch.ready <= 1'b0;
        out_wait <= out_wait - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    out_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int p;
    int n;
    int nmsg;
    int mlen;
    int j;
    int i;
    bit [6:0] lv;

    // known values on every input from time zero
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = vac_pkg::CFG_DIRECTION;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = vac_pkg::FUNC_KEY;
    in_ch.char_in = '0;
    in_ch.first = 1'b0;
    out_ch.ready = 1'b0;
    hold_go = 1'b0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: encrypt, repeating key of three
    write_reg(vac_pkg::CFG_KEY_LENGTH, 7'd3);
    offer(vac_pkg::FUNC_KEY, "b", 1'b1);
    offer(vac_pkg::FUNC_KEY, 8'hff, 1'b0);     // key char outside alphabet
    offer(vac_pkg::FUNC_KEY, ".", 1'b0);
    offer(vac_pkg::FUNC_MSG, "a", 1'b1);
    offer(vac_pkg::FUNC_MSG, "Z", 1'b0);
    offer(vac_pkg::FUNC_MSG, 8'h00, 1'b0);     // message char outside alphabet
    offer(vac_pkg::FUNC_MSG, ",", 1'b0);
    offer(vac_pkg::FUNC_MSG, " ", 1'b0);
    wait_idle();

    // directed: decrypt, autokey running into the plaintext history
    write_reg(vac_pkg::CFG_DIRECTION, 7'd1);
    write_reg(vac_pkg::CFG_KEY_MODE, 7'(vac_pkg::MODE_AUTOKEY));
    offer(vac_pkg::FUNC_MSG, ".", 1'b1);
    offer(vac_pkg::FUNC_MSG, "A", 1'b0);
    offer(vac_pkg::FUNC_MSG, "z", 1'b0);
    offer(vac_pkg::FUNC_MSG, "q", 1'b0);
    offer(vac_pkg::FUNC_MSG, "x", 1'b0);
    wait_idle();

    // key length lowered below the current slot, message continues
    write_reg(vac_pkg::CFG_KEY_LENGTH, 7'd2);
    offer(vac_pkg::FUNC_MSG, "m", 1'b0);
    offer(vac_pkg::FUNC_MSG, "k", 1'b0);
    wait_idle();

    // zero key length acts as one
    write_reg(vac_pkg::CFG_DIRECTION, 7'(vac_pkg::DIR_ENC));
    write_reg(vac_pkg::CFG_KEY_LENGTH, 7'd0);
    offer(vac_pkg::FUNC_MSG, "c", 1'b1);
    offer(vac_pkg::FUNC_MSG, "d", 1'b0);
    wait_idle();

    // oversized key length clamps to the store size
    write_reg(vac_pkg::CFG_KEY_MODE, 7'd0);
    write_reg(vac_pkg::CFG_KEY_LENGTH, 7'd127);
    offer(vac_pkg::FUNC_MSG, "e", 1'b1);
    offer(vac_pkg::FUNC_MSG, "f", 1'b0);
    wait_idle();

    // random phases: new settings, key load, messages, a little noise
    fed = 0;
    results_seen = 0;
    p = 0;
    while (fed < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       lv = 7'(vac_pkg::KEY_MAX);
        1:       lv = 7'd0;
        2:       lv = 7'($urandom_range(vac_pkg::KEY_MAX + 1, 127));
        3, 4:    lv = 7'($urandom_range(1, vac_pkg::KEY_MAX));
        default: lv = 7'($urandom_range(1, 8));
      endcase
      write_reg(vac_pkg::CFG_DIRECTION, 7'($urandom_range(0, 1)));
      write_reg(vac_pkg::CFG_KEY_MODE, 7'($urandom_range(0, 1)));
      write_reg(vac_pkg::CFG_KEY_LENGTH, lv);
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);

      // fresh key most of the time, sometimes long enough to wrap the store
      if ($urandom_range(0, 3) != 0) begin
        n = eff_len() + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0);
        for (i = 0; i < n; i++) offer(vac_pkg::FUNC_KEY, rand_char(), i == 0);
      end

      nmsg = $urandom_range(1, 3);
      for (j = 0; j < nmsg; j++) begin
        mlen = $urandom_range(1, 2 * eff_len() + 4);
        // first message sometimes carries on from the previous settings
        offer(vac_pkg::FUNC_MSG, rand_char(), !(j == 0 && $urandom_range(0, 4) == 0));
        for (i = 1; i < mlen; i++) offer(vac_pkg::FUNC_MSG, rand_char(), 1'b0);
      end

      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++)
        offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));

      // one phase backs up the pipeline behind a stalled receiver
      if (p == 2) begin
        in_burst = 1'b1;
        for (i = 0; i < 50; i++) offer(vac_pkg::FUNC_MSG, rand_char(), 1'b0);
        hold_go = 1'b1;
      end

      wait_idle();
      p++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0)
      flag_error($sformatf("%0d output transactions never arrived", expected_chars.size()));
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== vigenere_autokey_stream_cipher.f =====
hw/rtl/vac_pkg.sv
hw/rtl/vac_if.sv
hw/rtl/vac_ram.sv
hw/rtl/vac_ctrl.sv
hw/rtl/vac_alu.sv
hw/rtl/vigenere_autokey_stream_cipher.sv
dv/testbench.sv
